/* rtl/core/bcm_pkg.sv */
// bcm_pkg: shared types, register indexes and constants of the battery cell monitor
// used by bcm_sermul and battery_cell_monitor_top; no dependencies
`default_nettype none

package bcm_pkg;

  localparam int NumCells  = 3;
  localparam int IdxW      = 2;
  localparam int TapW      = 12;
  localparam int GainW     = 16;
  localparam int WeightW   = 9;
  localparam int ThrW      = 15;
  localparam int CellW     = 16;
  localparam int SubW      = 18;
  localparam int SatW      = 22;
  localparam int McandW    = 18;
  localparam int MplierW   = 12;
  localparam int ProdW     = 30;
  localparam int MulSteps  = 12;
  localparam int MulCntW   = 4;
  localparam int FracBits  = 8;
  localparam int ScaledW   = 20;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [IdxW-1:0]    LastCell   = 2'd2;
  localparam logic [WeightW-1:0] WeightOne  = 9'd256;

  localparam logic [WeightW-1:0] RstWeight  = 9'd128;
  localparam logic [ThrW-1:0]    RstWarnThr = 15'd3300;
  localparam logic [ThrW-1:0]    RstErrThr  = 15'd3100;
  localparam logic [GainW-1:0]   RstGainOne   = 16'd653;
  localparam logic [GainW-1:0]   RstGainTwo   = 16'd1308;
  localparam logic [GainW-1:0]   RstGainThree = 16'd1966;

  localparam logic signed [SatW-1:0] SatMax = 22'sd32767;
  localparam logic signed [SatW-1:0] SatMin = -22'sd32768;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AVG_WEIGHT  = 3'd0,
    REG_WARN_THR    = 3'd1,
    REG_ERR_THR     = 3'd2,
    REG_GAIN_ONE    = 3'd3,
    REG_GAIN_TWO    = 3'd4,
    REG_GAIN_THREE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP_MUL,
    ST_AVG_SETUP,
    ST_AVG_MUL,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [McandW-1:0] mcand;
    logic [MplierW-1:0]       mplier;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ProdW-1:0] prod;
  } mul_rsp_t;

  function automatic logic signed [CellW-1:0] sat16(input logic signed [SatW-1:0] v);
    logic signed [CellW-1:0] r;
    if (v > SatMax) begin
      r = 16'sh7fff;
    end else if (v < SatMin) begin
      r = 16'sh8000;
    end else begin
      r = v[CellW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bcm_in_if.sv */
// bcm_in_if: input channel carrying the three tap readings
// depends on bcm_pkg
`default_nettype none

interface bcm_in_if;
  logic                          valid;
  logic                          ready;
  logic [bcm_pkg::TapW-1:0]      tap_one_mv;
  logic [bcm_pkg::TapW-1:0]      tap_two_mv;
  logic [bcm_pkg::TapW-1:0]      tap_three_mv;

  modport source (output valid, tap_one_mv, tap_two_mv, tap_three_mv, input ready);
  modport sink   (input valid, tap_one_mv, tap_two_mv, tap_three_mv, output ready);
endinterface

`default_nettype wire

/* rtl/core/bcm_out_if.sv */
// bcm_out_if: result channel carrying the cell averages and sticky flags
// depends on bcm_pkg
`default_nettype none

interface bcm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bcm_pkg::CellW-1:0]  cell_one_avg_mv;
  logic signed [bcm_pkg::CellW-1:0]  cell_two_avg_mv;
  logic signed [bcm_pkg::CellW-1:0]  cell_three_avg_mv;
  logic                              warning_flag;
  logic                              error_flag;

  modport source (output valid, cell_one_avg_mv, cell_two_avg_mv, cell_three_avg_mv,
                  warning_flag, error_flag, input ready);
  modport sink   (input valid, cell_one_avg_mv, cell_two_avg_mv, cell_three_avg_mv,
                  warning_flag, error_flag, output ready);
endinterface

`default_nettype wire

/* rtl/core/bcm_cfg_if.sv */
// bcm_cfg_if: register write channel, index and data
// depends on bcm_pkg
`default_nettype none

interface bcm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bcm_pkg::CfgIdxW-1:0]    index;
  logic [bcm_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/bcm_sermul.sv */
// bcm_sermul: bit-serial shift-and-add multiplier, signed multiplicand by unsigned multiplier
// one multiplier bit per cycle; depends on bcm_pkg
`default_nettype none

module bcm_sermul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  bcm_pkg::mul_req_t  req,
  output bcm_pkg::mul_rsp_t  rsp
);

  logic signed [bcm_pkg::ProdW-1:0]  acc_r, acc_nxt;
  logic signed [bcm_pkg::ProdW-1:0]  mcand_r, mcand_nxt;
  logic [bcm_pkg::MplierW-1:0]       mplier_r, mplier_nxt;
  logic [bcm_pkg::MulCntW-1:0]       cnt_r, cnt_nxt;
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = bcm_pkg::ProdW'(req.mcand);
      mplier_nxt = req.mplier;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = bcm_pkg::MulCntW'(cnt_r + 1'b1);
      if (cnt_r == bcm_pkg::MulCntW'(bcm_pkg::MulSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

`default_nettype wire

/* rtl/core/battery_cell_monitor_top.sv */
// battery_cell_monitor_top: three-cell stack monitor, tap scaling, cell differences,
// moving averages and sticky undervoltage flags; depends on bcm_pkg, the bcm_*_if
// interfaces and bcm_sermul
//
//   channel  dir  payload                                              transfer
//   in_ch    in   tap_one_mv, tap_two_mv, tap_three_mv                  valid & ready
//   out_ch   out  cell_one/two/three_avg_mv, warning_flag, error_flag    valid & ready
//   cfg_ch   in   index, data                                            valid & ready
//
// each cell takes two 12-step products on the shared bit-serial multiplier, first the
// scaled tap and then the weighted step of its moving average.
// in_ch.ready is high only while idle; a new item is taken while a result still waits.
// cfg_ch.ready is always high. rst_n resets registers to their defaults, the averages
// to INITIAL_CELL_MV and both flags to zero.
`default_nettype none

module battery_cell_monitor_top #(
  parameter int INITIAL_CELL_MV = 3700
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bcm_in_if.sink      in_ch,
  bcm_out_if.source   out_ch,
  bcm_cfg_if.sink     cfg_ch
);

  localparam int NC = bcm_pkg::NumCells;

  logic [bcm_pkg::WeightW-1:0]  weight_r;
  logic [bcm_pkg::ThrW-1:0]     warn_thr_r;
  logic [bcm_pkg::ThrW-1:0]     err_thr_r;
  logic [bcm_pkg::GainW-1:0]    gain_r [NC];

  bcm_pkg::seq_state_t              state_r, state_nxt;
  logic [bcm_pkg::IdxW-1:0]         idx_r, idx_nxt;
  logic [bcm_pkg::TapW-1:0]         tap_r [NC];
  logic [bcm_pkg::TapW-1:0]         tap_nxt [NC];
  logic signed [bcm_pkg::SubW-1:0]  sub_r, sub_nxt;
  logic signed [bcm_pkg::CellW-1:0] cell_r, cell_nxt;
  logic signed [bcm_pkg::CellW-1:0] avg_r [NC];
  logic signed [bcm_pkg::CellW-1:0] avg_nxt [NC];
  logic                             warn_r, warn_nxt;
  logic                             err_r, err_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic signed [bcm_pkg::CellW-1:0] out_avg_r [NC];
  logic signed [bcm_pkg::CellW-1:0] out_avg_nxt [NC];
  logic                             out_warn_r, out_warn_nxt;
  logic                             out_err_r, out_err_nxt;

  bcm_pkg::mul_req_t mul_req;
  bcm_pkg::mul_rsp_t mul_rsp;

  logic [bcm_pkg::WeightW-1:0]      weight_eff;
  logic [bcm_pkg::ScaledW-1:0]      scaled;
  logic signed [bcm_pkg::SatW-1:0]  diff;
  logic signed [bcm_pkg::CellW-1:0] cell_sat;
  logic signed [bcm_pkg::CellW:0]   delta;
  logic signed [bcm_pkg::SatW-1:0]  step;
  logic signed [bcm_pkg::CellW-1:0] avg_new;
  logic [bcm_pkg::IdxW-1:0]         idx_inc;

  bcm_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r   <= bcm_pkg::RstWeight;
      warn_thr_r <= bcm_pkg::RstWarnThr;
      err_thr_r  <= bcm_pkg::RstErrThr;
      gain_r[0]  <= bcm_pkg::RstGainOne;
      gain_r[1]  <= bcm_pkg::RstGainTwo;
      gain_r[2]  <= bcm_pkg::RstGainThree;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bcm_pkg::REG_AVG_WEIGHT: weight_r   <= cfg_ch.data[bcm_pkg::WeightW-1:0];
        bcm_pkg::REG_WARN_THR:   warn_thr_r <= cfg_ch.data[bcm_pkg::ThrW-1:0];
        bcm_pkg::REG_ERR_THR:    err_thr_r  <= cfg_ch.data[bcm_pkg::ThrW-1:0];
        bcm_pkg::REG_GAIN_ONE:   gain_r[0]  <= cfg_ch.data;
        bcm_pkg::REG_GAIN_TWO:   gain_r[1]  <= cfg_ch.data;
        bcm_pkg::REG_GAIN_THREE: gain_r[2]  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcm_pkg::ST_IDLE;
      idx_r       <= '0;
      warn_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        avg_r[i] <= bcm_pkg::CellW'(INITIAL_CELL_MV);
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      warn_r      <= warn_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NC; i++) begin
        avg_r[i] <= avg_nxt[i];
      end
    end
    sub_r      <= sub_nxt;
    cell_r     <= cell_nxt;
    out_warn_r <= out_warn_nxt;
    out_err_r  <= out_err_nxt;
    for (int i = 0; i < NC; i++) begin
      tap_r[i]     <= tap_nxt[i];
      out_avg_r[i] <= out_avg_nxt[i];
    end
  end

  // datapath around the shared multiplier
  assign weight_eff = (weight_r > bcm_pkg::WeightOne) ? bcm_pkg::WeightOne : weight_r;
  assign scaled     = mul_rsp.prod[bcm_pkg::FracBits +: bcm_pkg::ScaledW];
  assign diff       = $signed({2'b00, scaled}) - bcm_pkg::SatW'(sub_r);
  assign cell_sat   = bcm_pkg::sat16(diff);
  assign delta      = $signed({cell_r[bcm_pkg::CellW-1], cell_r})
                    - $signed({avg_r[idx_r][bcm_pkg::CellW-1], avg_r[idx_r]});
  assign step       = bcm_pkg::SatW'(mul_rsp.prod >>> bcm_pkg::FracBits);
  assign avg_new    = bcm_pkg::sat16(bcm_pkg::SatW'(avg_r[idx_r]) + step);
  assign idx_inc    = bcm_pkg::IdxW'(idx_r + 1'b1);

  assign in_ch.ready = (state_r == bcm_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    cell_nxt      = cell_r;
    warn_nxt      = warn_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_warn_nxt  = out_warn_r;
    out_err_nxt   = out_err_r;
    for (int i = 0; i < NC; i++) begin
      tap_nxt[i]     = tap_r[i];
      avg_nxt[i]     = avg_r[i];
      out_avg_nxt[i] = out_avg_r[i];
    end
    mul_req = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bcm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          tap_nxt[0]     = in_ch.tap_one_mv;
          tap_nxt[1]     = in_ch.tap_two_mv;
          tap_nxt[2]     = in_ch.tap_three_mv;
          idx_nxt        = '0;
          sub_nxt        = '0;
          mul_req.start  = 1'b1;
          mul_req.mcand  = $signed({2'b00, gain_r[0]});
          mul_req.mplier = in_ch.tap_one_mv;
          state_nxt      = bcm_pkg::ST_TAP_MUL;
        end
      end
      bcm_pkg::ST_TAP_MUL: begin
        if (mul_rsp.done) begin
          cell_nxt  = cell_sat;
          sub_nxt   = sub_r + bcm_pkg::SubW'(cell_sat);
          state_nxt = bcm_pkg::ST_AVG_SETUP;
        end
      end
      bcm_pkg::ST_AVG_SETUP: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = bcm_pkg::McandW'(delta);
        mul_req.mplier = bcm_pkg::MplierW'(weight_eff);
        state_nxt      = bcm_pkg::ST_AVG_MUL;
      end
      bcm_pkg::ST_AVG_MUL: begin
        if (mul_rsp.done) begin
          avg_nxt[idx_r] = avg_new;
          if (avg_new < $signed({1'b0, warn_thr_r})) begin
            warn_nxt = 1'b1;
          end
          if (avg_new < $signed({1'b0, err_thr_r})) begin
            err_nxt = 1'b1;
          end
          if (idx_r == bcm_pkg::LastCell) begin
            state_nxt = bcm_pkg::ST_FINISH;
          end else begin
            idx_nxt        = idx_inc;
            mul_req.start  = 1'b1;
            mul_req.mcand  = $signed({2'b00, gain_r[idx_inc]});
            mul_req.mplier = tap_r[idx_inc];
            state_nxt      = bcm_pkg::ST_TAP_MUL;
          end
        end
      end
      bcm_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          for (int i = 0; i < NC; i++) begin
            out_avg_nxt[i] = avg_r[i];
          end
          out_warn_nxt  = warn_r;
          out_err_nxt   = err_r;
          out_valid_nxt = 1'b1;
          state_nxt     = bcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bcm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.cell_one_avg_mv   = out_avg_r[0];
  assign out_ch.cell_two_avg_mv   = out_avg_r[1];
  assign out_ch.cell_three_avg_mv = out_avg_r[2];
  assign out_ch.warning_flag      = out_warn_r;
  assign out_ch.error_flag        = out_err_r;

endmodule

`default_nettype wire
